// ===== rtl/imuid_pkg.sv =====
// Shared types and constants for the IMU impact detector.
// No dependencies; imported by every module of the block.
package imuid_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_THR_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_THR_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_IMPACT_THR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_SAMPLES = 3'd6;

  // Reset values of the configuration registers
  localparam logic signed [10:0] RST_OFFSET_X       = 11'sd0;
  localparam logic signed [10:0] RST_OFFSET_Y       = 11'sd0;
  localparam logic [15:0]        RST_GYRO_SCALE     = 16'd2621;
  localparam logic signed [15:0] RST_IMPACT_THR_X   = -16'sd200;
  localparam logic signed [15:0] RST_BLOCK_THR_X    = 16'sd50;
  localparam logic [14:0]        RST_YAW_IMPACT_THR = 15'd100;
  localparam logic [7:0]         RST_SETTLE_SAMPLES = 8'd25;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // Forward impact codes
  localparam logic [1:0] FWD_NONE     = 2'b00;
  localparam logic [1:0] FWD_RIGHT    = 2'b01;
  localparam logic [1:0] FWD_LEFT     = 2'b10;
  localparam logic [1:0] FWD_STRAIGHT = 2'b11;

  // Side tests on y acceleration
  localparam logic signed [15:0] Y_HIT_LEFT    = -16'sd100;
  localparam logic signed [15:0] Y_HIT_RIGHT   = 16'sd100;
  localparam logic signed [15:0] Y_QUIET_LEFT  = 16'sd80;
  localparam logic signed [15:0] Y_QUIET_RIGHT = -16'sd80;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic signed [10:0] offset_x;
    logic signed [10:0] offset_y;
    logic [15:0]        gyro_scale;
    logic signed [15:0] impact_thr_x;
    logic signed [15:0] block_thr_x;
    logic [14:0]        yaw_impact_thr;
    logic [7:0]         settle_samples;
  } cfg_t;

  // Preprocessed request held in the input register
  typedef struct packed {
    logic               op;
    logic               ongoing;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] step;
  } front_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/imuid_front.sv =====
// Input register of the impact detector: negates and offsets the accelerations
// and forms the rounded fixed-point yaw step. Depends on imuid_pkg.
module imuid_front
  import imuid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic               ongoing,
  input  logic signed [15:0] accel_x_raw,
  input  logic signed [15:0] accel_y_raw,
  input  logic signed [15:0] gyro_z_rate,
  input  logic               down_free,
  output logic               advance,
  output front_item_t        item
);

  logic              item_valid;
  logic              load;
  logic signed [17:0] x_wide;
  logic signed [17:0] y_wide;
  logic signed [32:0] prod;
  logic signed [33:0] prod_rnd;
  front_item_t       item_next;

  assign advance  = item_valid && down_free;
  assign in_stall = item_valid && !down_free;
  assign load     = in_valid && !in_stall;

  always_comb begin
    x_wide   = -{{2{accel_x_raw[15]}}, accel_x_raw} + {{7{cfg.offset_x[10]}}, cfg.offset_x};
    y_wide   = -{{2{accel_y_raw[15]}}, accel_y_raw} + {{7{cfg.offset_y[10]}}, cfg.offset_y};
    prod     = gyro_z_rate * $signed({1'b0, cfg.gyro_scale});
    // round to nearest, halves upward, then drop 16 fraction bits
    prod_rnd = {prod[32], prod} + 34'sd32768;
    item_next.op      = op;
    item_next.ongoing = ongoing;
    item_next.x       = sat16(x_wide);
    item_next.y       = sat16(y_wide);
    item_next.step    = prod_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/imuid_track.sv =====
// Tracking state of the impact detector: yaw integration, extremes, impact
// tests and the result valid. The state registers drive the result fields.
// Depends on imuid_pkg.
module imuid_track
  import imuid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               advance,
  input  front_item_t        item,
  output logic               down_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         impact_forward,
  output logic               impact_left,
  output logic               impact_right,
  output logic signed [31:0] yaw_total,
  output logic signed [15:0] peak_x,
  output logic signed [15:0] trough_x,
  output logic signed [15:0] peak_y,
  output logic signed [15:0] trough_y,
  output logic signed [15:0] peak_yaw_step,
  output logic signed [15:0] trough_yaw_step
);

  logic [7:0]         sample_count;
  logic [7:0]         sample_count_next;
  logic [1:0]         forward_code_next;
  logic               left_flag_next;
  logic               right_flag_next;
  logic signed [31:0] yaw_acc_next;
  logic signed [15:0] x_max_next;
  logic signed [15:0] x_min_next;
  logic signed [15:0] y_max_next;
  logic signed [15:0] y_min_next;
  logic signed [15:0] step_max_next;
  logic signed [15:0] step_min_next;
  logic signed [32:0] yaw_sum;
  logic signed [16:0] thr_pos;
  logic signed [16:0] thr_neg;
  logic               settled;

  assign down_free = !out_valid || !out_stall;

  always_comb begin
    yaw_sum = {yaw_total[31], yaw_total} + {{17{item.step[15]}}, item.step};
    thr_pos = $signed({2'b00, cfg.yaw_impact_thr});
    thr_neg = -thr_pos;

    sample_count_next = sample_count;
    forward_code_next = impact_forward;
    left_flag_next    = impact_left;
    right_flag_next   = impact_right;
    yaw_acc_next      = yaw_total;
    x_max_next        = peak_x;
    x_min_next        = trough_x;
    y_max_next        = peak_y;
    y_min_next        = trough_y;
    step_max_next     = peak_yaw_step;
    step_min_next     = trough_yaw_step;
    settled           = 1'b0;

    if (item.op == OP_START) begin
      sample_count_next = '0;
      forward_code_next = FWD_NONE;
      left_flag_next    = 1'b0;
      right_flag_next   = 1'b0;
      yaw_acc_next      = '0;
      x_max_next        = '0;
      x_min_next        = '0;
      y_max_next        = '0;
      y_min_next        = '0;
      step_max_next     = '0;
      step_min_next     = '0;
    end else begin
      if (yaw_sum[32] != yaw_sum[31]) begin
        yaw_acc_next = yaw_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        yaw_acc_next = yaw_sum[31:0];
      end
      if (sample_count != COUNT_MAX) begin
        sample_count_next = sample_count + 8'd1;
      end
      if (item.ongoing) begin
        settled = sample_count_next >= cfg.settle_samples;
        if (item.x < trough_x)              x_min_next    = item.x;
        if (item.x > peak_x)                x_max_next    = item.x;
        if (item.y < trough_y)              y_min_next    = item.y;
        if (item.y > peak_y)                y_max_next    = item.y;
        if (item.step > peak_yaw_step)      step_max_next = item.step;
        if (item.step < trough_yaw_step)    step_min_next = item.step;

        if (item.x < cfg.impact_thr_x || (settled && x_max_next < cfg.block_thr_x)) begin
          if ($signed({step_min_next[15], step_min_next}) < thr_neg) begin
            forward_code_next = FWD_RIGHT;
          end else if ($signed({step_max_next[15], step_max_next}) > thr_pos) begin
            forward_code_next = FWD_LEFT;
          end else begin
            forward_code_next = FWD_STRAIGHT;
          end
        end
        if (item.y < Y_HIT_LEFT || (settled && y_max_next < Y_QUIET_LEFT)) begin
          left_flag_next = 1'b1;
        end
        if (item.y > Y_HIT_RIGHT || (settled && y_min_next > Y_QUIET_RIGHT)) begin
          right_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      sample_count    <= '0;
      impact_forward  <= FWD_NONE;
      impact_left     <= 1'b0;
      impact_right    <= 1'b0;
      yaw_total       <= '0;
      peak_x          <= '0;
      trough_x        <= '0;
      peak_y          <= '0;
      trough_y        <= '0;
      peak_yaw_step   <= '0;
      trough_yaw_step <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // state only moves when the result slot is free, so it doubles as the result
      if (advance) begin
        sample_count    <= sample_count_next;
        impact_forward  <= forward_code_next;
        impact_left     <= left_flag_next;
        impact_right    <= right_flag_next;
        yaw_total       <= yaw_acc_next;
        peak_x          <= x_max_next;
        trough_x        <= x_min_next;
        peak_y          <= y_max_next;
        trough_y        <= y_min_next;
        peak_yaw_step   <= step_max_next;
        trough_yaw_step <= step_min_next;
      end
    end
  end

endmodule

// ===== rtl/imu_impact_detector.sv =====
// Top level of the IMU impact detector: configuration registers, input stage
// and tracking stage. Depends on imuid_pkg, imuid_front and imuid_track.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    op, ongoing, accel_x_raw, accel_y_raw, gyro_z_rate
//   out      out_valid / out_stall  impact_forward .. trough_yaw_step (one per request)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
// Each request gives one result; one request per cycle while out_stall is low.
// The input register holds the offset accelerations and the 16x16 yaw step product;
// the tracking stage adds the step, updates the extremes and runs the impact tests.
// Reset (rst, synchronous) restores default configuration and clears all tracking.
// A stalled result holds the state; the input register still takes one more request.
module imu_impact_detector
  import imuid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic                 ongoing,
  input  logic signed [15:0]   accel_x_raw,
  input  logic signed [15:0]   accel_y_raw,
  input  logic signed [15:0]   gyro_z_rate,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           impact_forward,
  output logic                 impact_left,
  output logic                 impact_right,
  output logic signed [31:0]   yaw_total,
  output logic signed [15:0]   peak_x,
  output logic signed [15:0]   trough_x,
  output logic signed [15:0]   peak_y,
  output logic signed [15:0]   trough_y,
  output logic signed [15:0]   peak_yaw_step,
  output logic signed [15:0]   trough_yaw_step,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t        cfg;
  front_item_t item;
  logic        advance;
  logic        down_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x       <= RST_OFFSET_X;
      cfg.offset_y       <= RST_OFFSET_Y;
      cfg.gyro_scale     <= RST_GYRO_SCALE;
      cfg.impact_thr_x   <= RST_IMPACT_THR_X;
      cfg.block_thr_x    <= RST_BLOCK_THR_X;
      cfg.yaw_impact_thr <= RST_YAW_IMPACT_THR;
      cfg.settle_samples <= RST_SETTLE_SAMPLES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OFFSET_X:       cfg.offset_x       <= cfg_data[10:0];
        CFG_OFFSET_Y:       cfg.offset_y       <= cfg_data[10:0];
        CFG_GYRO_SCALE:     cfg.gyro_scale     <= cfg_data;
        CFG_IMPACT_THR_X:   cfg.impact_thr_x   <= cfg_data;
        CFG_BLOCK_THR_X:    cfg.block_thr_x    <= cfg_data;
        CFG_YAW_IMPACT_THR: cfg.yaw_impact_thr <= cfg_data[14:0];
        CFG_SETTLE_SAMPLES: cfg.settle_samples <= cfg_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  imuid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .ongoing     (ongoing),
    .accel_x_raw (accel_x_raw),
    .accel_y_raw (accel_y_raw),
    .gyro_z_rate (gyro_z_rate),
    .down_free   (down_free),
    .advance     (advance),
    .item        (item)
  );

  imuid_track u_track (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .advance         (advance),
    .item            (item),
    .down_free       (down_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .impact_forward  (impact_forward),
    .impact_left     (impact_left),
    .impact_right    (impact_right),
    .yaw_total       (yaw_total),
    .peak_x          (peak_x),
    .trough_x        (trough_x),
    .peak_y          (peak_y),
    .trough_y        (trough_y),
    .peak_yaw_step   (peak_yaw_step),
    .trough_yaw_step (trough_yaw_step)
  );

  // Extremes start at zero, so the peak never drops below the trough or zero.
  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    peak_x >= 16'sd0 && trough_x <= 16'sd0 && peak_y >= 16'sd0 && trough_y <= 16'sd0
    && peak_yaw_step >= trough_yaw_step)
    else $error("tracked extremes out of order");

  // A start request leaves the cleared state as its result.
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.op == OP_START |=> yaw_total == 32'sd0 && impact_forward == FWD_NONE
    && !impact_left && !impact_right)
    else $error("start request did not clear tracking");

  // Impact flags are sticky unless a start request passes.
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    (impact_left || impact_right) && !(advance && item.op == OP_START)
    |=> impact_left >= $past(impact_left) && impact_right >= $past(impact_right))
    else $error("impact flag dropped without a start request");

  // The input side stalls only while a result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free result slot");

endmodule
